[hdl/assert_macros.svh]
// assertion macros shared by the rate meter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, disabled while reset is asserted
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[hdl/piwrm_pkg.sv]
// shared types, constants and decode functions of the rate meter
package piwrm_pkg;

    localparam int WINDOW_DEF = 30;
    localparam int IVAL_W     = 16;
    localparam int SUM_W      = 22;
    localparam int RATE_W     = 22;
    localparam int CNT_W      = 16;
    localparam int LAMP_W     = 2;
    localparam int SEG_W      = 7;
    localparam int DIV_CNT_W  = $clog2(RATE_W + 1);

    localparam logic [15:0]    RATE_SCALE_RST = 16'd6000;
    localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
    localparam logic [7:0]     DISPLAY_MAX    = 8'd159;

    localparam logic KIND_RATE   = 1'b0;
    localparam logic KIND_PERIOD = 1'b1;

    localparam logic MODE_PULSE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [LAMP_W-1:0] LAMP_GREEN  = 2'd0;
    localparam logic [LAMP_W-1:0] LAMP_YELLOW = 2'd1;
    localparam logic [LAMP_W-1:0] LAMP_RED    = 2'd2;

    typedef struct packed {
        logic              start;
        logic [IVAL_W-1:0] ival;
    } win_cmd_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
    } win_sts_t;

    typedef struct packed {
        logic              kind;
        logic [RATE_W-1:0] rate;
        logic [SUM_W-1:0]  window_sum;
        logic [CNT_W-1:0]  pulse_number;
        logic [LAMP_W-1:0] lit_lamp;
        logic [CNT_W-1:0]  period_count;
        logic [SEG_W-1:0]  tens_segments;
        logic [SEG_W-1:0]  units_segments;
    } res_t;

    // segments a..g on bits 6..0
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'h0:    seg = 7'h7E;
            4'h1:    seg = 7'h30;
            4'h2:    seg = 7'h6D;
            4'h3:    seg = 7'h79;
            4'h4:    seg = 7'h33;
            4'h5:    seg = 7'h5B;
            4'h6:    seg = 7'h5F;
            4'h7:    seg = 7'h70;
            4'h8:    seg = 7'h7F;
            4'h9:    seg = 7'h7B;
            4'hA:    seg = 7'h77;
            4'hB:    seg = 7'h1F;
            4'hC:    seg = 7'h4E;
            4'hD:    seg = 7'h3D;
            4'hE:    seg = 7'h4F;
            4'hF:    seg = 7'h47;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // green, yellow, red, yellow
    function automatic logic [LAMP_W-1:0] lamp_of(input logic [1:0] phase);
        logic [LAMP_W-1:0] lamp;
        case (phase)
            2'd0:    lamp = LAMP_GREEN;
            2'd1:    lamp = LAMP_YELLOW;
            2'd2:    lamp = LAMP_RED;
            2'd3:    lamp = LAMP_YELLOW;
            default: lamp = LAMP_GREEN;
        endcase
        return lamp;
    endfunction

    // tens by reciprocal 205/2048, exact below 160 with the 4-bit result
    function automatic logic [3:0] tens_of(input logic [7:0] shown);
        logic [15:0] prod;
        prod = 16'(shown) * 16'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] units_of(input logic [7:0] shown);
        logic [7:0] tens_x10;
        logic [7:0] diff;
        tens_x10 = 8'(tens_of(shown)) * 8'd10;
        diff     = shown - tens_x10;
        return diff[3:0];
    endfunction

endpackage

[hdl/pulse_interval_window_rate_meter.sv]
// top level of the pulse interval window rate meter
//
// channel   signals                        carries
// -------   ----------------------------   ------------------------------------------
// item      item_valid / item_stall        mode, interval
// result    result_valid / result_stall    kind, rate, window_sum, pulse_number,
//                                          lit_lamp, period_count, tens/units_segments
// config    rate_scale_we                  rate_scale_data
//
// a pulse interval request runs from one acceptance to the next through
// one window read, one writeback, 22 steps of the serial divider, taking
// the quotient, loading the result register and a return to idle
// an end of period tick goes from idle straight to the result register load,
// and a zero interval is dropped while the sequencer stays in idle
// reset (rst_n, async, active low) clears the window valid bits, total,
// counters and lamp phase, and sets rate_scale to 6000; no clearing pass
// a stalled result sits in the output register while the next request is taken
module pulse_interval_window_rate_meter #(
    parameter int WINDOW = piwrm_pkg::WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               rate_scale_we,
    input  logic [15:0]                        rate_scale_data,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               mode,
    input  logic [piwrm_pkg::IVAL_W-1:0]       interval,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               kind,
    output logic [piwrm_pkg::RATE_W-1:0]       rate,
    output logic [piwrm_pkg::SUM_W-1:0]        window_sum,
    output logic [piwrm_pkg::CNT_W-1:0]        pulse_number,
    output logic [piwrm_pkg::LAMP_W-1:0]       lit_lamp,
    output logic [piwrm_pkg::CNT_W-1:0]        period_count,
    output logic [piwrm_pkg::SEG_W-1:0]        tens_segments,
    output logic [piwrm_pkg::SEG_W-1:0]        units_segments
);
    import piwrm_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WIN  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [15:0]       scale_reg, scale_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        phase_reg, phase_next;
    res_t              res_reg, res_next;
    res_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    win_cmd_t          win_cmd;
    win_sts_t          win_sts;
    logic              div_start;
    logic [RATE_W-1:0] div_num;
    logic              div_done;
    logic [RATE_W-1:0] div_quo;

    logic              item_acc;
    logic              out_free;
    logic [7:0]        shown;
    logic [3:0]        tens_digit;
    logic [3:0]        units_digit;
    logic [CNT_W-1:0]  cnt_inc;

    piwrm_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (win_cmd),
        .sts   (win_sts)
    );

    piwrm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (win_sts.sum),
        .done  (div_done),
        .quo   (div_quo)
    );

    // one request at a time through the window and divider
    assign item_stall = (state_reg != S_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    // display count saturates before the digit split
    assign shown       = (cnt_reg > CNT_W'(DISPLAY_MAX)) ? DISPLAY_MAX : cnt_reg[7:0];
    assign tens_digit  = tens_of(shown);
    assign units_digit = units_of(shown);
    assign cnt_inc     = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // numerator scale times window depth, fits 22 bits for any depth up to 64
    assign div_num   = RATE_W'(scale_reg * WINDOW);
    assign div_start = (state_reg == S_WIN) && win_sts.done;

    assign win_cmd.start = item_acc && (mode == MODE_PULSE) && (interval != '0);
    assign win_cmd.ival  = interval;

    always_comb
    begin
        state_next     = state_reg;
        scale_next     = scale_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (rate_scale_we)
        begin
            scale_next = rate_scale_data;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    if (mode == MODE_TICK)
                    begin
                        res_next                = '0;
                        res_next.kind           = KIND_PERIOD;
                        res_next.window_sum     = win_sts.sum;
                        res_next.period_count   = cnt_reg;
                        res_next.tens_segments  = seg_of(tens_digit);
                        res_next.units_segments = seg_of(units_digit);
                        cnt_next                = '0;
                        state_next              = S_DONE;
                    end
                    else if (interval != '0)
                    begin
                        state_next = S_WIN;
                    end
                end
            end
            S_WIN:
            begin
                // writeback done, total now includes the new interval
                if (win_sts.done)
                begin
                    res_next              = '0;
                    res_next.kind         = KIND_RATE;
                    res_next.window_sum   = win_sts.sum;
                    res_next.pulse_number = cnt_inc;
                    res_next.lit_lamp     = lamp_of(phase_reg);
                    cnt_next              = cnt_inc;
                    phase_next            = phase_reg + 1'b1;
                    state_next            = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next.rate = div_quo;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scale_reg     <= RATE_SCALE_RST;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign kind           = out_reg.kind;
    assign rate           = out_reg.rate;
    assign window_sum     = out_reg.window_sum;
    assign pulse_number   = out_reg.pulse_number;
    assign lit_lamp       = out_reg.lit_lamp;
    assign period_count   = out_reg.period_count;
    assign tens_segments  = out_reg.tens_segments;
    assign units_segments = out_reg.units_segments;

`include "assert_macros.svh"

    `ASSERT_CLKD(a_top_win_done_state, clk, rst_n, win_sts.done |-> state_reg == S_WIN, "window done outside window wait")
    `ASSERT_CLKD(a_top_div_done_state, clk, rst_n, div_done |-> state_reg == S_DIV, "divider done outside divide wait")
    `ASSERT_CLKD(a_top_tick_clears, clk, rst_n, (item_acc && mode == MODE_TICK) |=> cnt_reg == '0, "period count not cleared by tick")

endmodule

[hdl/piwrm_window.sv]
// interval window memory with read-modify-write of the running total
module piwrm_window #(
    parameter int WINDOW = piwrm_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  piwrm_pkg::win_cmd_t cmd,
    output piwrm_pkg::win_sts_t sts
);
    import piwrm_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [IVAL_W-1:0] mem [WINDOW];
    logic [IVAL_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [IVAL_W-1:0] ival_reg;
    logic              pend_reg;
    logic              done_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [WINDOW-1:0] valid_reg;
    logic [SUM_W-1:0]  total_reg;
    logic [SUM_W-1:0]  total_next;
    logic [IVAL_W-1:0] old_val;

    // entries never written read as zero
    assign old_val    = rd_valid_reg ? rd_data_reg : '0;
    assign total_next = total_reg - SUM_W'(old_val) + SUM_W'(ival_reg);
    assign slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            mem[slot_reg] <= ival_reg;
        end
        if (cmd.start)
        begin
            rd_data_reg <= mem[slot_reg];
            ival_reg    <= cmd.ival;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            slot_reg     <= '0;
            valid_reg    <= '0;
            total_reg    <= '0;
        end
        else
        begin
            pend_reg <= cmd.start;
            done_reg <= pend_reg;
            if (cmd.start)
            begin
                rd_valid_reg <= valid_reg[slot_reg];
            end
            if (pend_reg)
            begin
                valid_reg[slot_reg] <= 1'b1;
                total_reg           <= total_next;
                slot_reg            <= slot_next;
            end
        end
    end

    assign sts.done = done_reg;
    assign sts.sum  = total_reg;

`include "assert_macros.svh"

    `ASSERT_CLKD(a_win_no_overlap, clk, rst_n, cmd.start |-> !pend_reg && !done_reg, "window request overlaps a pending one")
    `ASSERT_CLKD(a_win_wb_follows_rd, clk, rst_n, pend_reg |-> $past(cmd.start), "writeback without a preceding read")
    `ASSERT_CLKD(a_win_sum_covers_new, clk, rst_n, done_reg |-> total_reg >= SUM_W'(ival_reg), "window sum below newest interval")

endmodule

[hdl/piwrm_divider.sv]
// serial restoring divider, one quotient bit per cycle
module piwrm_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [piwrm_pkg::RATE_W-1:0]    num,
    input  logic [piwrm_pkg::SUM_W-1:0]     den,
    output logic                            done,
    output logic [piwrm_pkg::RATE_W-1:0]    quo
);
    import piwrm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RATE_W-1:0]    q_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     den_reg;
    logic                 den_zero_reg;
    logic [SUM_W:0]       partial;
    logic [SUM_W:0]       diff;
    logic                 ge;

    assign partial = {rem_reg, q_reg[RATE_W-1]};
    assign ge      = partial >= {1'b0, den_reg};
    assign diff    = partial - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg        <= num;
            rem_reg      <= '0;
            den_reg      <= den;
            den_zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[SUM_W-1:0] : partial[SUM_W-1:0];
            q_reg   <= {q_reg[RATE_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(RATE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // empty sum gives zero
    assign quo  = den_zero_reg ? '0 : q_reg;
    assign done = done_reg;

`include "assert_macros.svh"

    `ASSERT_CLKD(a_div_start_idle, clk, rst_n, start |-> !busy_reg && !done_reg, "divider restarted while busy")
    `ASSERT_CLKD(a_div_done_ends, clk, rst_n, done_reg |-> !busy_reg && $past(busy_reg), "divider done without a run")
    `ASSERT_CLKD(a_div_cnt_range, clk, rst_n, busy_reg |-> cnt_reg < DIV_CNT_W'(RATE_W), "divider step count overrun")

endmodule
